@@ src/skc_pkg.sv @@
// Package for the SAD keyframe candidate search: shared types and codes.
// No dependencies.
package skc_pkg;

   typedef enum logic [1:0] {
      KIND_STORED   = 2'd0,
      KIND_CAND     = 2'd1,
      KIND_NO_CAND  = 2'd2,
      KIND_FULL     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_MARGIN = 2'd0,
      REG_THRESH = 2'd1,
      REG_PIXELS = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_QSCAN = 2'd1,
      ST_SSCAN = 2'd2,
      ST_EMIT  = 2'd3
   } state_type;

   localparam int unsigned SCORE_W   = 20;
   localparam int unsigned RESULT_CAP = 64;
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

endpackage

@@ src/skc_if.sv @@
// Handshake channels of the candidate search: request, response, CSR write.
// Depends on skc_pkg.
interface skc_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] pixel;
   logic       frame_end;
   logic [6:0] query_id;
   modport source (output valid, func, pixel, frame_end, query_id, input ready);
   modport sink   (input valid, func, pixel, frame_end, query_id, output ready);
endinterface

interface skc_rsp_if;
   logic                     valid;
   logic                     ready;
   skc_pkg::kind_type        kind;
   logic [5:0]               frame_index;
   logic [skc_pkg::SCORE_W-1:0] score;
   logic                     run_end;
   modport source (output valid, kind, frame_index, score, run_end, input ready);
   modport sink   (input valid, kind, frame_index, score, run_end, output ready);
endinterface

interface skc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [12:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/skc_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module skc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ src/sad_keyframe_candidate_search_unit.sv @@
// Top level of the SAD keyframe candidate search; uses skc_pkg, skc_if, skc_ram.
//
// Keyframe thumbnails live in one RAM (frame index : pixel position) and per-frame
// scores in a second RAM. A query beat sweeps all stored frames, one frame per
// cycle through the score RAM read/modify/write path, or every frame slot on the
// first pixel of a query, which also zeroes every score. After the last query
// beat, candidates are found by repeated sweeps over the score RAM, each picking
// the next smallest (score, index) pair that passes the margin and threshold
// tests. Request ready is low while a sweep or report runs, or while a response
// is still waiting to be taken. No clearing pass after reset; frame data is
// valid only once written.
module sad_keyframe_candidate_search_unit #(
   parameter int MAX_FRAMES   = 64,
   parameter int THUMB_PIXELS = 4096
) (
   input  logic      clock,
   input  logic      reset,
   skc_req_if.sink   req_bus,
   skc_rsp_if.source rsp_bus,
   skc_csr_if.sink   csr_bus
);
   import skc_pkg::*;

   localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FW1 = $clog2(MAX_FRAMES + 1);
   localparam int PW  = $clog2(THUMB_PIXELS);
   localparam int CW  = $clog2(RESULT_CAP + 1);
   localparam logic [FW1-1:0] NF_MAX = FW1'(MAX_FRAMES);
   localparam logic [PW:0]    TP_C   = (PW+1)'(THUMB_PIXELS);
   localparam logic [CW-1:0]  CAP_C  = CW'(RESULT_CAP);

   // configuration
   logic [6:0]  margin_ff;
   logic [7:0]  thresh_ff;
   logic [12:0] pixels_ff;
   logic [20:0] limit_ff;

   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= 7'd30;
         thresh_ff <= 8'd10;
         pixels_ff <= 13'd4096;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_MARGIN: margin_ff <= csr_bus.data[6:0];
            REG_THRESH: thresh_ff <= csr_bus.data[7:0];
            REG_PIXELS: pixels_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end
   always_ff @(posedge clock) limit_ff <= thresh_ff * pixels_ff;

   // control and data registers
   state_type        state_ff, state_in;
   logic [FW1-1:0]   nf_ff, nf_in;
   logic [PW:0]      sptr_ff, sptr_in, qptr_ff, qptr_in;
   logic [FW1-1:0]   cnt_ff, cnt_in;
   logic             rdv_ff, rdv_in;
   logic [FW-1:0]    rdi_ff, rdi_in;
   logic             first_ff, first_in, qlast_ff, qlast_in;
   logic [7:0]       qpix_ff, qpix_in;
   logic [6:0]       qid_ff, qid_in;
   logic             found_ff, found_in;
   logic [SCORE_W-1:0] best_s_ff, best_s_in, last_s_ff, last_s_in, pend_s_ff, pend_s_in;
   logic [FW-1:0]    best_i_ff, best_i_in, last_i_ff, last_i_in, pend_i_ff, pend_i_in;
   logic             pend_v_ff, pend_v_in;
   logic [CW-1:0]    nq_ff, nq_in;
   kind_type         em_k_ff, em_k_in;
   logic [FW-1:0]    em_i_ff, em_i_in;
   logic [SCORE_W-1:0] em_s_ff, em_s_in;
   logic             fin_ff, fin_in;
   logic             rv_ff, rv_in, rl_ff, rl_in;
   kind_type         rk_ff, rk_in;
   logic [5:0]       ri_ff, ri_in;
   logic [SCORE_W-1:0] rs_ff, rs_in;

   // memories
   logic               px_we, sc_we;
   logic [FW+PW-1:0]   px_waddr, px_raddr;
   logic [7:0]         px_rdata;
   logic [FW-1:0]      sc_waddr, sc_raddr;
   logic [SCORE_W-1:0] sc_wdata, sc_rdata;

   skc_ram #(.WIDTH(8), .DEPTH(MAX_FRAMES * (2 ** PW))) u_pix_ram (
      .clock(clock), .we(px_we), .waddr(px_waddr), .wdata(req_bus.pixel),
      .raddr(px_raddr), .rdata(px_rdata));
   skc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_FRAMES)) u_score_ram (
      .clock(clock), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
      .raddr(sc_raddr), .rdata(sc_rdata));

   logic acc_req, rsp_free, full, scan_end;
   logic [FW1-1:0] scan_n;
   assign rsp_free = !rv_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && rsp_free;
   assign acc_req = req_bus.valid && req_bus.ready;
   assign full = (nf_ff >= NF_MAX);
   assign scan_n = (state_ff == ST_QSCAN && first_ff) ? NF_MAX : nf_ff;
   assign scan_end = (cnt_ff == scan_n) && !rdv_ff;

   // per-frame datapath at read return
   logic [8:0]  absd;
   logic [20:0] sum;
   logic [SCORE_W-1:0] base, upd;
   logic in_use, qual, better;
   logic [7:0] idx_gap;
   always_comb begin
      in_use = ({1'b0, rdi_ff} < (FW+1)'(nf_ff));
      absd = (qpix_ff >= px_rdata) ? {1'b0, qpix_ff - px_rdata} : {1'b0, px_rdata - qpix_ff};
      base = first_ff ? '0 : sc_rdata;
      sum  = {1'b0, base} + 21'(absd);
      upd  = !in_use ? '0 : (sum > 21'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
      idx_gap = (9'(qid_ff) >= 9'(rdi_ff)) ? 8'(9'(qid_ff) - 9'(rdi_ff))
                                          : 8'(9'(rdi_ff) - 9'(qid_ff));
      qual = (idx_gap >= 8'(margin_ff)) && (21'(sc_rdata) < limit_ff) &&
             ((nq_ff == '0) || (sc_rdata > last_s_ff) ||
              ((sc_rdata == last_s_ff) && (rdi_ff > last_i_ff)));
      better = !found_ff || (sc_rdata < best_s_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (acc_req && req_bus.func) begin
               if (qptr_ff < TP_C) state_in = ST_QSCAN;
               else if (req_bus.frame_end) state_in = ST_SSCAN;
            end
         ST_QSCAN:
            if (scan_end) state_in = qlast_ff ? ST_SSCAN : ST_IDLE;
         ST_SSCAN:
            if (scan_end && (!found_ff || pend_v_ff || nq_ff + 1'b1 == CAP_C))
               state_in = ST_EMIT;
         ST_EMIT:
            if (rsp_free) begin
               if (fin_ff) state_in = ST_IDLE;
               else if (nq_ff != CAP_C) state_in = ST_SSCAN;
            end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath / outputs
   always_comb begin
      nf_in = nf_ff; sptr_in = sptr_ff; qptr_in = qptr_ff;
      cnt_in = cnt_ff; rdv_in = 1'b0; rdi_in = cnt_ff[FW-1:0];
      first_in = first_ff; qlast_in = qlast_ff; qpix_in = qpix_ff; qid_in = qid_ff;
      found_in = found_ff; best_s_in = best_s_ff; best_i_in = best_i_ff;
      last_s_in = last_s_ff; last_i_in = last_i_ff;
      pend_v_in = pend_v_ff; pend_s_in = pend_s_ff; pend_i_in = pend_i_ff;
      nq_in = nq_ff; em_k_in = em_k_ff; em_i_in = em_i_ff; em_s_in = em_s_ff;
      fin_in = fin_ff;
      rv_in = rv_ff && !rsp_bus.ready; rk_in = rk_ff; ri_in = ri_ff; rs_in = rs_ff;
      rl_in = rl_ff;
      px_we = 1'b0;
      px_waddr = {nf_ff[FW-1:0], sptr_ff[PW-1:0]};
      px_raddr = {cnt_ff[FW-1:0], qptr_ff[PW-1:0]};
      sc_raddr = cnt_ff[FW-1:0];
      sc_we = 1'b0; sc_waddr = rdi_ff; sc_wdata = upd;

      case (state_ff)
         ST_IDLE:
            if (acc_req) begin
               if (!req_bus.func) begin
                  if (full) begin
                     sptr_in = '0;
                     if (req_bus.frame_end) begin
                        rv_in = 1'b1; rk_in = KIND_FULL; ri_in = '0; rs_in = '0;
                        rl_in = 1'b1;
                     end
                  end else begin
                     if (sptr_ff < TP_C) begin
                        px_we = 1'b1;
                        sptr_in = sptr_ff + 1'b1;
                     end
                     if (req_bus.frame_end) begin
                        rv_in = 1'b1; rk_in = KIND_STORED; ri_in = 6'(nf_ff);
                        rs_in = '0; rl_in = 1'b1;
                        nf_in = nf_ff + 1'b1;
                        sptr_in = '0;
                     end
                  end
               end else begin
                  qpix_in = req_bus.pixel;
                  qid_in = req_bus.query_id;
                  qlast_in = req_bus.frame_end;
                  first_in = (qptr_ff == '0);
                  cnt_in = '0;
                  found_in = 1'b0; nq_in = '0; pend_v_in = 1'b0;
                  if (req_bus.frame_end && !(qptr_ff < TP_C)) qptr_in = '0;
               end
            end
         ST_QSCAN: begin
            if (cnt_ff != scan_n) begin
               rdv_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (rdv_ff) sc_we = 1'b1;
            if (scan_end) begin
               cnt_in = '0;
               qptr_in = qlast_ff ? '0 : qptr_ff + 1'b1;
            end
         end
         ST_SSCAN: begin
            if (cnt_ff != scan_n) begin
               rdv_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (rdv_ff && qual && better) begin
               found_in = 1'b1; best_s_in = sc_rdata; best_i_in = rdi_ff;
            end
            if (scan_end) begin
               cnt_in = '0;
               found_in = 1'b0;
               if (found_ff) begin
                  nq_in = nq_ff + 1'b1;
                  last_s_in = best_s_ff; last_i_in = best_i_ff;
                  pend_v_in = 1'b1; pend_s_in = best_s_ff; pend_i_in = best_i_ff;
                  em_k_in = KIND_CAND;
                  if (pend_v_ff) begin
                     em_s_in = pend_s_ff; em_i_in = pend_i_ff; fin_in = 1'b0;
                  end else begin
                     em_s_in = best_s_ff; em_i_in = best_i_ff; fin_in = 1'b1;
                  end
               end else begin
                  fin_in = 1'b1;
                  pend_v_in = 1'b0;
                  if (pend_v_ff) begin
                     em_k_in = KIND_CAND; em_s_in = pend_s_ff; em_i_in = pend_i_ff;
                  end else begin
                     em_k_in = KIND_NO_CAND; em_s_in = '0; em_i_in = '0;
                  end
               end
            end
         end
         ST_EMIT:
            if (rsp_free) begin
               rv_in = 1'b1; rk_in = em_k_ff; ri_in = 6'(em_i_ff); rs_in = em_s_ff;
               rl_in = fin_ff;
               cnt_in = '0;
               if (!fin_ff && nq_ff == CAP_C) begin
                  // cap reached: the pending candidate is the final one
                  em_s_in = pend_s_ff; em_i_in = pend_i_ff; fin_in = 1'b1;
               end
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nf_ff <= '0; sptr_ff <= '0; qptr_ff <= '0;
         cnt_ff <= '0; rdv_ff <= 1'b0; rv_ff <= 1'b0;
         found_ff <= 1'b0; pend_v_ff <= 1'b0; nq_ff <= '0; fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nf_ff <= nf_in; sptr_ff <= sptr_in; qptr_ff <= qptr_in;
         cnt_ff <= cnt_in; rdv_ff <= rdv_in; rv_ff <= rv_in;
         found_ff <= found_in; pend_v_ff <= pend_v_in; nq_ff <= nq_in; fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      rdi_ff <= rdi_in; first_ff <= first_in; qlast_ff <= qlast_in;
      qpix_ff <= qpix_in; qid_ff <= qid_in;
      best_s_ff <= best_s_in; best_i_ff <= best_i_in;
      last_s_ff <= last_s_in; last_i_ff <= last_i_in;
      pend_s_ff <= pend_s_in; pend_i_ff <= pend_i_in;
      em_k_ff <= em_k_in; em_i_ff <= em_i_in; em_s_ff <= em_s_in;
      rk_ff <= rk_in; ri_ff <= ri_in; rs_ff <= rs_in; rl_ff <= rl_in;
   end

   assign rsp_bus.valid       = rv_ff;
   assign rsp_bus.kind        = rk_ff;
   assign rsp_bus.frame_index = ri_ff;
   assign rsp_bus.score       = rs_ff;
   assign rsp_bus.run_end     = rl_ff;
endmodule

@@ bench/tb_sad_keyframe_candidate_search_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sad_keyframe_candidate_search_unit: stores and queries thumbnails,
// predicts every ack, candidate list and status beat. Depends on skc_pkg, skc_if, the DUT.
module tb_sad_keyframe_candidate_search_unit;
   import skc_pkg::*;

   localparam int NFRAMES      = 64;
   localparam int NPIX         = 4096;
   localparam int QUIET_LIMIT  = 20000;  // cycles with no beat on any channel
   localparam int DRAIN_CYCLES = 300;    // covers one full-store pixel sweep and more
   localparam int RANDOM_BEATS = 140;
   localparam logic [1:0] REG_UNUSED = 2'd3;  // index with no register behind it

   typedef struct {
      kind_type        kind;
      bit [5:0]        frame_index;
      bit [SCORE_W-1:0] score;
      bit              run_end;
   } result_type;

   // Scoreboard: mirror of the frame store, scores and CSRs, plus the queue of
   // beats still owed by the DUT.
   class sad_scoreboard_type;
      bit [7:0]    thumbs [NFRAMES][NPIX];
      int unsigned n_frames, store_ptr, query_ptr;
      int unsigned scores [NFRAMES];
      int unsigned margin = 30, thresh = 10, pixels = 4096;
      result_type  pending [$];
      int          errors;

      function void owe(kind_type k, bit [5:0] idx, bit [SCORE_W-1:0] s, bit last);
         result_type r;
         r.kind = k; r.frame_index = idx; r.score = s; r.run_end = last;
         pending.insert(pending.size(), r);
      endfunction

      function void write_reg(logic [1:0] index, logic [12:0] data);
         case (index)
            REG_MARGIN: margin = data[6:0];
            REG_THRESH: thresh = data[7:0];
            REG_PIXELS: pixels = data;
            default: ;
         endcase
      endfunction

      // candidate report: margin and threshold filter, ascending (score, index)
      function void report(bit [6:0] qid);
         int unsigned limit, gap, s, i;
         int          picks [$];
         limit = thresh * pixels;
         for (int f = 0; f < n_frames && f < NFRAMES; f++) begin
            gap = (qid >= f) ? qid - f : f - qid;
            s = scores[f];
            if (gap < margin || s >= limit) continue;
            i = picks.size();
            while (i > 0 && scores[picks[i-1]] > s) i--;
            picks.insert(i, f);
         end
         if (picks.size() == 0) begin
            owe(KIND_NO_CAND, '0, '0, 1'b1);
            return;
         end
         for (int k = 0; k < picks.size() && k < RESULT_CAP; k++)
            owe(KIND_CAND, 6'(picks[k]), SCORE_W'(scores[picks[k]]),
                k == picks.size() - 1 || k == RESULT_CAP - 1);
      endfunction

      function void note_request(bit func, bit [7:0] pixel, bit frame_end, bit [6:0] qid);
         int unsigned d, s;
         if (!func) begin
            if (n_frames >= NFRAMES) begin
               store_ptr = 0;
               if (frame_end) owe(KIND_FULL, '0, '0, 1'b1);
               return;
            end
            if (store_ptr < NPIX) begin
               thumbs[n_frames][store_ptr] = pixel;
               store_ptr++;
            end
            if (frame_end) begin
               owe(KIND_STORED, 6'(n_frames), '0, 1'b1);
               n_frames++;
               store_ptr = 0;
            end
            return;
         end
         if (query_ptr == 0) foreach (scores[f]) scores[f] = 0;
         if (query_ptr < NPIX) begin
            for (int f = 0; f < n_frames && f < NFRAMES; f++) begin
               d = (pixel >= thumbs[f][query_ptr]) ? pixel - thumbs[f][query_ptr]
                                                   : thumbs[f][query_ptr] - pixel;
               s = scores[f] + d;
               scores[f] = (s > SCORE_MAX) ? SCORE_MAX : s;
            end
            query_ptr++;
         end
         if (frame_end) begin
            query_ptr = 0;
            report(qid);
         end
      endfunction

      function void check_result(kind_type kind, bit [5:0] idx, bit [SCORE_W-1:0] score,
                                 bit run_end);
         result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat: kind %0d index %0d score %0d", kind, idx, score);
            errors++;
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (kind != e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, kind); errors++;
         end
         if (idx != e.frame_index) begin
            $error("frame_index: expected %0d, got %0d", e.frame_index, idx); errors++;
         end
         if (score != e.score) begin
            $error("score: expected %0d, got %0d", e.score, score); errors++;
         end
         if (run_end != e.run_end) begin
            $error("run_end: expected %0d, got %0d", e.run_end, run_end); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   skc_req_if req_bus ();
   skc_rsp_if rsp_bus ();
   skc_csr_if csr_bus ();

   sad_keyframe_candidate_search_unit #(
      .MAX_FRAMES  (NFRAMES),
      .THUMB_PIXELS(NPIX)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   sad_scoreboard_type sb = new();
   bit          gaps_on = 1'b1;
   int unsigned beats_sent;
   int unsigned quiet_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response sink, checker and watchdog. Values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.kind, rsp_bus.frame_index, rsp_bus.score, rsp_bus.run_end);
      if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_sad_keyframe_candidate_search_unit: done, errors");
         $finish;
      end
      // backpressure: stall ~19% of cycles unless in the no-idle stretch
      rsp_bus.ready <= gaps_on ? ($urandom_range(99) >= 19) : 1'b1;
   end

   // One request beat. valid stays high into the next beat unless a gap is drawn.
   task automatic send_beat(bit func, bit [7:0] pixel, bit frame_end, bit [6:0] qid);
      if (gaps_on && $urandom_range(99) < 19) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 19) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= func;
      req_bus.pixel     <= pixel;
      req_bus.frame_end <= frame_end;
      req_bus.query_id  <= qid;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(func, pixel, frame_end, qid);
      beats_sent++;
   endtask

   // fixed < 0: random pixels; otherwise every pixel takes that value
   task automatic store_frame(int len, int fixed);
      for (int i = 0; i < len; i++)
         send_beat(1'b0, fixed < 0 ? 8'($urandom_range(255)) : 8'(fixed), i == len - 1,
                   7'($urandom_range(127)));
   endtask

   // query stream; a store frame may be slipped in mid-query (joins late)
   task automatic query_frame(int len, bit [6:0] qid, bit slip_store, int fixed);
      int at;
      at = $urandom_range(len - 1);
      for (int i = 0; i < len; i++) begin
         if (slip_store && i == at) store_frame($urandom_range(16, 8), -1);
         send_beat(1'b1, fixed < 0 ? 8'($urandom_range(255)) : 8'(fixed), i == len - 1, qid);
      end
   endtask

   // Hold off until every owed beat is back, then let any last sweep finish.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [12:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.write_reg(index, data);
      @(posedge clock);
   endtask

   task automatic configure(logic [12:0] margin, logic [12:0] thresh, logic [12:0] pixels);
      drain();
      csr_write(REG_MARGIN, margin);
      csr_write(REG_THRESH, thresh);
      csr_write(REG_PIXELS, pixels);
   endtask

   // random traffic: frames of 8..16 pixels, queries of at most 8 once anything is
   // stored; a store slips into a query only when the query has at most 8 pixels,
   // so no query pixel ever lands on an unwritten store position
   task automatic random_traffic(int unsigned n_beats);
      int unsigned stop_at, qlen;
      stop_at = beats_sent + n_beats;
      while (beats_sent < stop_at) begin
         if ($urandom_range(99) < 40) begin
            store_frame($urandom_range(16, 8), -1);
         end else begin
            qlen = (sb.n_frames == 0) ? $urandom_range(12, 1) : $urandom_range(8, 1);
            query_frame(qlen, 7'($urandom_range(127)),
                        qlen <= 8 && $urandom_range(99) < 15, -1);
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.func    = 1'b0;
      req_bus.pixel   = '0;
      req_bus.frame_end = 1'b0;
      req_bus.query_id  = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // queries with nothing stored: no candidate
      query_frame(4, 7'd127, 1'b0, -1);
      query_frame(1, 7'd0, 1'b0, 255);
      // a random first frame, then two identical frames for a score tie
      store_frame(12, -1);
      store_frame(8, 255);
      store_frame(8, 255);
      store_frame(8, 0);
      configure(13'd0, 13'd255, 13'd4096);      // everything qualifies
      query_frame(8, 7'd0, 1'b0, 0);             // extremes against 0/255 frames
      query_frame(8, 7'd64, 1'b1, 255);          // a frame closed mid-query joins late
      configure(13'd2, 13'd0, 13'd4096);         // zero threshold: no candidate
      query_frame(3, 7'd1, 1'b0, -1);
      configure(13'd127, 13'd255, 13'd0);        // zero pixel count, huge margin
      csr_write(REG_UNUSED, 13'h1FFF);
      query_frame(2, 7'd127, 1'b0, -1);

      // --- random, across several register settings ---
      configure(13'd0, 13'd128, 13'd8191);
      random_traffic(RANDOM_BEATS / 4);
      configure(13'd30, 13'd10, 13'd4096);
      gaps_on = 1'b0;                           // long stretch with no idling
      random_traffic(RANDOM_BEATS / 4);
      gaps_on = 1'b1;
      configure(13'd3, 13'd60, 13'd8);
      random_traffic(RANDOM_BEATS / 4);
      configure(13'd64, 13'd255, 13'd1);
      random_traffic(RANDOM_BEATS / 4);

      // fill the store with one-pixel frames, then hit it while full;
      // from here on queries are one pixel long
      configure(13'd1, 13'd255, 13'd4096);
      while (sb.n_frames < NFRAMES) store_frame(1, -1);
      store_frame(3, -1);
      for (int i = 0; i < 6; i++)
         query_frame(1, 7'($urandom_range(127)), 1'b0, -1);

      drain();
      if (sb.errors == 0)
         $display("tb_sad_keyframe_candidate_search_unit: done, clean");
      else
         $display("tb_sad_keyframe_candidate_search_unit: done, errors");
      $finish;
   end

endmodule
